[hw/rtl/qbs_pkg.sv]
`default_nettype none

package qbs_pkg;

    localparam logic [2:0] ST_START     = 3'h0;
    localparam logic [2:0] ST_CW_FINAL  = 3'h1;
    localparam logic [2:0] ST_CW_BEGIN  = 3'h2;
    localparam logic [2:0] ST_CW_NEXT   = 3'h3;
    localparam logic [2:0] ST_CCW_BEGIN = 3'h4;
    localparam logic [2:0] ST_CCW_FINAL = 3'h5;
    localparam logic [2:0] ST_CCW_NEXT  = 3'h6;

    localparam logic [5:0] FLAG_CW    = 6'h10;
    localparam logic [5:0] FLAG_CCW   = 6'h20;
    localparam logic [5:0] STATE_MASK = 6'h0F;
    localparam logic [5:0] FLAG_MASK  = 6'h30;

    localparam int         MAX_RESULTS    = 4;
    localparam int         CODE_W         = 3;
    localparam int         LEVEL_W        = 3;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [LEVEL_W-1:0] levels_t;
    typedef logic [7:0]         count_t;
    typedef logic [2:0]         dec_state_t;

    typedef struct packed {
        logic cw;
        logic ccw;
    } dec_evt_t;

    function automatic logic [5:0] st6(input dec_state_t s);
        return {3'b000, s};
    endfunction

    // full-step table: pin code is {A, B}
    function automatic logic [5:0] step_lookup(input dec_state_t st, input logic [1:0] pin);
        logic [5:0] r;
        r = st6(ST_START);
        case (st)
            ST_CW_FINAL:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CW_NEXT);
                    2'd1:    r = st6(ST_START);
                    2'd2:    r = st6(ST_CW_FINAL);
                    default: r = st6(ST_START) | FLAG_CW;
                endcase
            end
            ST_CW_BEGIN:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CW_NEXT);
                    2'd1:    r = st6(ST_CW_BEGIN);
                    default: r = st6(ST_START);
                endcase
            end
            ST_CW_NEXT:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CW_NEXT);
                    2'd1:    r = st6(ST_CW_BEGIN);
                    2'd2:    r = st6(ST_CW_FINAL);
                    default: r = st6(ST_START);
                endcase
            end
            ST_CCW_BEGIN:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CCW_NEXT);
                    2'd1:    r = st6(ST_START);
                    2'd2:    r = st6(ST_CCW_BEGIN);
                    default: r = st6(ST_START);
                endcase
            end
            ST_CCW_FINAL:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CCW_NEXT);
                    2'd1:    r = st6(ST_CCW_FINAL);
                    2'd2:    r = st6(ST_START);
                    default: r = st6(ST_START) | FLAG_CCW;
                endcase
            end
            ST_CCW_NEXT:
            begin
                case (pin)
                    2'd0:    r = st6(ST_CCW_NEXT);
                    2'd1:    r = st6(ST_CCW_FINAL);
                    2'd2:    r = st6(ST_CCW_BEGIN);
                    default: r = st6(ST_START);
                endcase
            end
            default:
            begin
                // start state, and the unreachable code 7
                case (pin)
                    2'd1:    r = st6(ST_CW_BEGIN);
                    2'd2:    r = st6(ST_CCW_BEGIN);
                    default: r = st6(ST_START);
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/qbs_channels.sv]
`default_nettype none

interface qbs_in_if;
    logic       valid;
    logic       ready;
    logic       enc_a;
    logic       enc_b;
    logic [2:0] button_levels;

    modport source (output valid, output enc_a, output enc_b, output button_levels,
                    input ready);
    modport sink   (input valid, input enc_a, input enc_b, input button_levels,
                    output ready);
endinterface

interface qbs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       last;

    modport source (output valid, output event_code, output last, input ready);
    modport sink   (input valid, input event_code, input last, output ready);
endinterface

interface qbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] debounce_ticks;

    modport source (output valid, output debounce_ticks, input ready);
    modport sink   (input valid, input debounce_ticks, output ready);
endinterface

`default_nettype wire

[hw/rtl/qbs_decoder.sv]
`default_nettype none

module qbs_decoder
    import qbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire logic     enc_a,
    input  wire logic     enc_b,
    output dec_evt_t      evt
);

    dec_state_t state_reg;
    dec_state_t state_next;
    logic [5:0] step;

    always_comb
    begin
        step       = step_lookup(state_reg, {enc_a, enc_b});
        state_next = step[2:0];
        evt.cw     = (step & FLAG_MASK) == FLAG_CW;
        evt.ccw    = (step & FLAG_MASK) == FLAG_CCW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/qbs_button_lane.sv]
`default_nettype none

module qbs_button_lane
    import qbs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   accept,
    input  wire logic   raw,
    input  wire count_t debounce_ticks,
    output logic        press
);

    logic   level_reg;
    logic   level_next;
    count_t count_reg;
    count_t count_next;
    count_t count_inc;
    logic   commit;

    always_comb
    begin
        count_inc  = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;
        commit     = (raw != level_reg) && (count_inc >= debounce_ticks);
        press      = commit && !raw;
        level_next = commit ? raw : level_reg;
        if (raw == level_reg || commit)
        begin
            count_next = '0;
        end
        else
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b1;
            count_reg <= '0;
        end
        else if (accept)
        begin
            level_reg <= level_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/qbs_merge.sv]
`default_nettype none

module qbs_merge
    import qbs_pkg::*;
#(
    parameter int EV_W = 5
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [EV_W-1:0] ev,
    output logic                 in_ready,
    output logic                 busy,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output code_t                out_code,
    output logic                 out_last
);

    logic [EV_W-1:0]  mask_reg;
    logic [EV_W-1:0]  mask_next;
    logic [EV_W-1:0]  ev_kept;
    logic [EV_W-1:0]  mask_left;
    code_t            pick;
    logic             found;
    logic [2:0]       seen;
    logic             load_out;
    logic             pick_last;
    logic             out_valid_reg;
    code_t            code_reg;
    logic             last_reg;

    // keep the first MAX_RESULTS events of the item
    always_comb
    begin
        seen    = '0;
        ev_kept = '0;
        for (int k = 0; k < EV_W; k++)
        begin
            if (ev[k] && int'(seen) < MAX_RESULTS)
            begin
                ev_kept[k] = 1'b1;
                seen       = seen + 3'd1;
            end
        end
    end

    always_comb
    begin
        found     = 1'b0;
        pick      = '0;
        mask_left = mask_reg;
        for (int k = 0; k < EV_W; k++)
        begin
            if (mask_reg[k] && !found)
            begin
                found        = 1'b1;
                pick         = code_t'(k);
                mask_left[k] = 1'b0;
            end
        end
        busy      = |mask_reg;
        pick_last = !(|mask_left);
        load_out  = busy && (!out_valid_reg || out_ready);
        in_ready  = !busy || (load_out && pick_last);
        if (accept)
        begin
            mask_next = ev_kept;
        end
        else if (load_out)
        begin
            mask_next = mask_left;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // codes follow bit position: cw, ccw, then 2 + button index
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            code_reg <= pick;
            last_reg <= pick_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_code  = code_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[hw/rtl/quadrature_and_button_scanner.sv]
// A taken tick's events go into the event mask register, then one by one into
// the single event output register. A tick causing zero or one event is taken
// every cycle unless the event output stalls; after one with n events (n up to
// 4) the next waits until its last event is loaded. Reset: decoder at start,
// buttons released, run counters zero, debounce 20, no events pending.
`default_nettype none

module quadrature_and_button_scanner
    import qbs_pkg::*;
#(
    parameter int BUTTON_COUNT = 3
)(
    input  wire logic clk,
    input  wire logic rst_n,
    qbs_in_if.sink    tick,
    qbs_out_if.source evt,
    qbs_cfg_if.sink   cfg
);

    localparam int EV_W = 2 + BUTTON_COUNT;

    logic            accept;
    logic            busy;
    logic            in_ready;
    count_t          debounce_reg;
    dec_evt_t        dec_evt;
    logic [EV_W-1:0] ev;

    assign accept    = tick.valid && in_ready;
    assign tick.ready = in_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            debounce_reg <= cfg.debounce_ticks;
        end
    end

    qbs_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .enc_a  (tick.enc_a),
        .enc_b  (tick.enc_b),
        .evt    (dec_evt)
    );

    assign ev[0] = dec_evt.cw;
    assign ev[1] = dec_evt.ccw;

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_lane
        logic raw;
        if (i < LEVEL_W)
        begin : g_pin
            assign raw = tick.button_levels[i];
        end
        else
        begin : g_tied
            assign raw = 1'b0;
        end

        qbs_button_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .accept         (accept),
            .raw            (raw),
            .debounce_ticks (debounce_reg),
            .press          (ev[2 + i])
        );
    end

    qbs_merge #(
        .EV_W (EV_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ev        (ev),
        .in_ready  (in_ready),
        .busy      (busy),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .out_code  (evt.event_code),
        .out_last  (evt.last)
    );

    a_one_detent: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dec_evt.cw, dec_evt.ccw}))
        else $error("cw and ccw detent in one tick");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> tick.ready)
        else $error("not ready with no events pending");

    a_events_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (|ev)) |=> busy)
        else $error("events of an accepted item lost");

endmodule

`default_nettype wire

[verif/tb_quadrature_and_button_scanner.sv]
`timescale 1ns / 100ps

module tb_quadrature_and_button_scanner;
    import qbs_pkg::*;

    localparam code_t      EV_CW        = 3'd0;
    localparam code_t      EV_CCW       = 3'd1;
    localparam code_t      EV_CLICK     = 3'd2;  // select and home follow on
    localparam int         BTN_TOTAL    = 3;
    localparam int         DRAIN_CYCLES = 4;
    // clockwise pin walk {A,B}: 3, 1, 0, 2
    localparam logic [7:0] ENC_PATH     = {2'd2, 2'd0, 2'd1, 2'd3};

    typedef struct packed {
        code_t code;
        logic  last;
    } event_rec_t;

    class event_scoreboard;
        dec_state_t dec_st;
        logic       level_q[BTN_TOTAL];
        count_t     run_q[BTN_TOTAL];
        count_t     debounce;
        event_rec_t awaited[$];
        int         fails;

        function new();
            dec_st   = ST_START;
            debounce = DEBOUNCE_RESET;
            fails    = 0;
            for (int i = 0; i < BTN_TOTAL; i++)
            begin
                level_q[i] = 1'b1;
                run_q[i]   = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fails++;
        endtask

        function int pending();
            return awaited.size();
        endfunction

        function void note_tick(logic a, logic b, levels_t lv);
            logic [23:0] row;
            logic [5:0]  nxt;
            code_t       hits[$];
            count_t      cnt;
            event_rec_t  rec;
            int          n;
            // row holds the next state for pin codes 3..0, high to low
            case (dec_st)
                ST_CW_FINAL:  row = {FLAG_CW, 6'(ST_CW_FINAL), 6'(ST_START), 6'(ST_CW_NEXT)};
                ST_CW_BEGIN:  row = {6'(ST_START), 6'(ST_START), 6'(ST_CW_BEGIN),
                                     6'(ST_CW_NEXT)};
                ST_CW_NEXT:   row = {6'(ST_START), 6'(ST_CW_FINAL), 6'(ST_CW_BEGIN),
                                     6'(ST_CW_NEXT)};
                ST_CCW_BEGIN: row = {6'(ST_START), 6'(ST_CCW_BEGIN), 6'(ST_START),
                                     6'(ST_CCW_NEXT)};
                ST_CCW_FINAL: row = {FLAG_CCW, 6'(ST_START), 6'(ST_CCW_FINAL),
                                     6'(ST_CCW_NEXT)};
                ST_CCW_NEXT:  row = {6'(ST_START), 6'(ST_CCW_BEGIN), 6'(ST_CCW_FINAL),
                                     6'(ST_CCW_NEXT)};
                default:      row = {6'(ST_START), 6'(ST_CCW_BEGIN), 6'(ST_CW_BEGIN),
                                     6'(ST_START)};
            endcase
            nxt    = row[6 * int'({a, b}) +: 6];
            dec_st = nxt[2:0];
            if ((nxt & FLAG_MASK) == FLAG_CW)
                hits.push_back(EV_CW);
            else if ((nxt & FLAG_MASK) == FLAG_CCW)
                hits.push_back(EV_CCW);

            for (int i = 0; i < BTN_TOTAL; i++)
            begin
                if (lv[i] == level_q[i])
                    run_q[i] = '0;
                else
                begin
                    cnt      = (run_q[i] == COUNT_MAX) ? COUNT_MAX : run_q[i] + 8'd1;
                    run_q[i] = cnt;
                    // zero debounce commits on the first disagreeing sample
                    if (cnt >= debounce)
                    begin
                        level_q[i] = lv[i];
                        run_q[i]   = '0;
                        if (!lv[i])
                            hits.push_back(EV_CLICK + code_t'(i));
                    end
                end
            end

            n = (hits.size() > MAX_RESULTS) ? MAX_RESULTS : hits.size();
            for (int k = 0; k < n; k++)
            begin
                rec.code = hits[k];
                rec.last = (k == n - 1);
                awaited.push_back(rec);
            end
        endfunction

        task check_event(code_t code, logic last);
            event_rec_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected event code %0d last %0b", code, last));
                return;
            end
            want = awaited.pop_front();
            if (code !== want.code)
                report($sformatf("event code %0d, expected %0d", code, want.code));
            if (last !== want.last)
                report($sformatf("last %0b on code %0d, expected %0b",
                                 last, want.code, want.last));
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    qbs_in_if  tick_ch();
    qbs_out_if evt_ch();
    qbs_cfg_if cfg_ch();

    quadrature_and_button_scanner u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    event_scoreboard sb;
    bit              calm = 1'b0;
    int              ready_hold = 0;
    logic [1:0]      enc_idx = 2'd0;
    logic            enc_cw = 1'b1;
    levels_t         want_lv = 3'b111;
    int              held[BTN_TOTAL];

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // event sink with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && evt_ch.valid && evt_ch.ready)
            sb.check_event(evt_ch.event_code, evt_ch.last);
        if (ready_hold > 0)
        begin
            ready_hold--;
            evt_ch.ready <= 1'b0;
        end
        else
        begin
            evt_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25)
                ready_hold = pick_gap();
        end
    end

    task automatic send_tick(input logic a, input logic b, input levels_t lv);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid         <= 1'b1;
        tick_ch.enc_a         <= a;
        tick_ch.enc_b         <= b;
        tick_ch.button_levels <= lv;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        sb.note_tick(a, b, lv);
    endtask

    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input count_t v);
        settle();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.debounce_ticks <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.debounce = v;
        repeat (2) @(posedge clk);
    endtask

    // mostly clean detent walks and held buttons, with bounce and stray pin codes
    task automatic run_random(input int n, input int hold_max);
        logic [1:0] pins;
        levels_t    lv;
        int         r;
        for (int t = 0; t < n; t++)
        begin
            if ($urandom_range(0, 99) < 8)
                enc_cw = ~enc_cw;
            r = $urandom_range(0, 99);
            if (r < 70)
                enc_idx = enc_cw ? enc_idx + 2'd1 : enc_idx - 2'd1;
            pins = (r < 85) ? ENC_PATH[2 * int'(enc_idx) +: 2] : 2'($urandom_range(0, 3));
            for (int i = 0; i < BTN_TOTAL; i++)
            begin
                if (held[i] == 0)
                begin
                    want_lv[i] = 1'($urandom_range(0, 1));
                    held[i]    = $urandom_range(1, hold_max);
                end
                else
                    held[i]--;
                lv[i] = want_lv[i] ^ ($urandom_range(0, 99) < 6);
            end
            send_tick(pins[1], pins[0], lv);
            if ($urandom_range(0, 99) < 3)
                settle();
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sb = new();
        for (int i = 0; i < BTN_TOTAL; i++)
            held[i] = 0;
        tick_ch.valid         = 1'b0;
        tick_ch.enc_a         = 1'b1;
        tick_ch.enc_b         = 1'b1;
        tick_ch.button_levels = 3'b111;
        evt_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.debounce_ticks = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encoder only, reset debounce
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b0, 1'b1, 3'b111);
        send_tick(1'b0, 1'b0, 3'b111);
        send_tick(1'b1, 1'b0, 3'b111);
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b1, 1'b0, 3'b111);
        send_tick(1'b0, 1'b0, 3'b111);
        send_tick(1'b0, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b0, 1'b0, 3'b111);
        send_tick(1'b1, 1'b1, 3'b111);

        // zero debounce: every change commits at once
        write_debounce(8'd0);
        send_tick(1'b1, 1'b1, 3'b000);
        send_tick(1'b0, 1'b1, 3'b111);
        send_tick(1'b0, 1'b0, 3'b111);
        send_tick(1'b1, 1'b0, 3'b111);
        send_tick(1'b1, 1'b1, 3'b000);  // detent plus three presses in one tick
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b110);
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b101);
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b011);
        send_tick(1'b1, 1'b1, 3'b111);

        write_debounce(8'd1);
        calm = 1'b1;
        run_random(40, 4);
        send_tick(1'b1, 1'b1, 3'b111);
        send_tick(1'b1, 1'b1, 3'b111);
        calm = 1'b0;

        // long debounce: click held until it finally commits
        write_debounce(8'd30);
        for (int t = 0; t < 32; t++)
        begin
            enc_idx = enc_idx + 2'd1;
            send_tick(ENC_PATH[2 * int'(enc_idx) + 1], ENC_PATH[2 * int'(enc_idx)], 3'b110);
        end

        write_debounce(8'd3);
        run_random(25, 10);
        write_debounce(8'd20);
        run_random(25, 45);
        write_debounce(8'd2);
        run_random(25, 8);

        tick_ch.valid <= 1'b0;
        for (int k = 0; k < 50000 && sb.pending() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d events never arrived", sb.pending()));
        if (sb.fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
